// ===== hw/rtl/tdef_pkg.sv =====
// Shared types, codes and the microcode program of the table-driven event state machine.
package tdef_pkg;

    localparam int STATE_W    = 5;
    localparam int SIG_IN_W   = 8;
    localparam int EIDX_W     = 3;
    localparam int KIND_W     = 3;
    localparam int RK_W       = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 32;
    localparam int UPC_W      = 4;

    localparam logic [KIND_W-1:0] KIND_PUSH      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RUN       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WR_ENTRY  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WR_PSEUDO = 3'd4;

    localparam logic [RK_W-1:0] RK_ACK    = 2'd0;
    localparam logic [RK_W-1:0] RK_REPORT = 2'd1;
    localparam logic [RK_W-1:0] RK_DONE   = 2'd2;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_FETCH = 4'd0;
    localparam upc_t UPC_RUN   = 4'd4;
    localparam upc_t UPC_ENTRY = 4'd7;
    localparam upc_t UPC_HIT   = 4'd11;
    localparam upc_t UPC_NEXT  = 4'd14;
    localparam upc_t UPC_SCAN  = 4'd5;
    localparam upc_t UPC_DONE  = 4'd15;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_FETCH,
        ACT_EXEC,
        ACT_ACK,
        ACT_SCAN_START,
        ACT_EI_CLR,
        ACT_EI_INC,
        ACT_HIT,
        ACT_REPORT,
        ACT_QI_INC,
        ACT_DONE
    } act_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_FIRE,
        COND_KIND_RUN,
        COND_QI_END,
        COND_CONSUMED,
        COND_EI_END,
        COND_NOT_PRESENT,
        COND_MATCH,
        COND_PSEUDO
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  jmp;
    } uword_t;

    typedef struct packed {
        logic no_fire;
        logic kind_run;
        logic qi_end;
        logic consumed;
        logic ei_end;
        logic not_present;
        logic match;
        logic pseudo;
        logic out_busy;
    } dp_status_t;

    function automatic uword_t ucode_rom(input upc_t upc);
        uword_t w;
        case (upc)
            4'd0:    w = '{ACT_FETCH,      COND_NO_FIRE,     UPC_FETCH};
            4'd1:    w = '{ACT_NONE,       COND_KIND_RUN,    UPC_RUN};
            4'd2:    w = '{ACT_EXEC,       COND_NEVER,       UPC_FETCH};
            4'd3:    w = '{ACT_ACK,        COND_ALWAYS,      UPC_FETCH};
            4'd4:    w = '{ACT_SCAN_START, COND_NEVER,       UPC_FETCH};
            4'd5:    w = '{ACT_NONE,       COND_QI_END,      UPC_DONE};
            4'd6:    w = '{ACT_EI_CLR,     COND_CONSUMED,    UPC_NEXT};
            4'd7:    w = '{ACT_NONE,       COND_EI_END,      UPC_NEXT};
            4'd8:    w = '{ACT_NONE,       COND_NOT_PRESENT, UPC_NEXT};
            4'd9:    w = '{ACT_NONE,       COND_MATCH,       UPC_HIT};
            4'd10:   w = '{ACT_EI_INC,     COND_ALWAYS,      UPC_ENTRY};
            4'd11:   w = '{ACT_HIT,        COND_NEVER,       UPC_FETCH};
            4'd12:   w = '{ACT_REPORT,     COND_PSEUDO,      UPC_NEXT};
            4'd13:   w = '{ACT_NONE,       COND_ALWAYS,      UPC_RUN};
            4'd14:   w = '{ACT_QI_INC,     COND_ALWAYS,      UPC_SCAN};
            4'd15:   w = '{ACT_DONE,       COND_ALWAYS,      UPC_FETCH};
            default: w = '{ACT_NONE,       COND_ALWAYS,      UPC_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/tdef_useq.sv =====
// Microcode sequencer: step counter, program ROM and conditional jumps.
module tdef_useq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tdef_pkg::dp_status_t status,
    output tdef_pkg::act_t       act
);

    tdef_pkg::upc_t   upc_reg;
    tdef_pkg::upc_t   upc_next;
    tdef_pkg::uword_t uw;
    logic             emit;
    logic             stall;
    logic             cond_hit;

    assign uw    = tdef_pkg::ucode_rom(upc_reg);
    assign emit  = (uw.act == tdef_pkg::ACT_ACK) || (uw.act == tdef_pkg::ACT_REPORT) ||
                   (uw.act == tdef_pkg::ACT_DONE);
    assign stall = emit && status.out_busy;

    always_comb
    begin
        case (uw.cond)
            tdef_pkg::COND_NEVER:       cond_hit = 1'b0;
            tdef_pkg::COND_ALWAYS:      cond_hit = 1'b1;
            tdef_pkg::COND_NO_FIRE:     cond_hit = status.no_fire;
            tdef_pkg::COND_KIND_RUN:    cond_hit = status.kind_run;
            tdef_pkg::COND_QI_END:      cond_hit = status.qi_end;
            tdef_pkg::COND_CONSUMED:    cond_hit = status.consumed;
            tdef_pkg::COND_EI_END:      cond_hit = status.ei_end;
            tdef_pkg::COND_NOT_PRESENT: cond_hit = status.not_present;
            tdef_pkg::COND_MATCH:       cond_hit = status.match;
            tdef_pkg::COND_PSEUDO:      cond_hit = status.pseudo;
            default:                    cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        if (stall)
        begin
            upc_next = upc_reg;
        end
        else if (cond_hit)
        begin
            upc_next = uw.jmp;
        end
        else
        begin
            upc_next = upc_reg + tdef_pkg::upc_t'(1);
        end
    end

    assign act = stall ? tdef_pkg::ACT_NONE : uw.act;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= tdef_pkg::UPC_FETCH;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== hw/rtl/tdef_dpath.sv =====
// Datapath: queue, transition table, pseudo flags, scan registers and output register.
module tdef_dpath #(
    parameter int NUM_STATES        = 32,
    parameter int ENTRIES_PER_STATE = 8,
    parameter int QUEUE_DEPTH       = 16,
    parameter int SIGNAL_BITS       = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tdef_pkg::act_t                    act,
    output tdef_pkg::dp_status_t              status,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tdef_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [tdef_pkg::KIND_W-1:0]       s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tdef_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic [tdef_pkg::RK_W-1:0]         m_tuser,
    output logic                              m_tlast
);

    localparam int SW        = tdef_pkg::STATE_W;
    localparam int SIG_W     = (SIGNAL_BITS < tdef_pkg::SIG_IN_W) ? SIGNAL_BITS
                                                                  : tdef_pkg::SIG_IN_W;
    localparam int QA_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int TBL_DEPTH = NUM_STATES * ENTRIES_PER_STATE;
    localparam int TA_W      = $clog2(TBL_DEPTH);
    localparam int EI_W      = $clog2(ENTRIES_PER_STATE + 1);
    localparam int PA_W      = $clog2(NUM_STATES);
    localparam int TW_W      = 1 + SW + SIG_W;

    // latched input beat
    logic [tdef_pkg::KIND_W-1:0] kind_reg;
    logic [SIG_W-1:0]            sig_reg;
    logic [SW-1:0]               st_reg;
    logic [tdef_pkg::EIDX_W-1:0] ein_reg;
    logic [SW-1:0]               tgt_reg;
    logic                        valid_reg;
    logic                        pbit_reg;

    logic [SW-1:0]    cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] qi_reg, qi_next;
    logic [EI_W-1:0]  ei_reg, ei_next;
    logic             err_reg, err_next;
    logic [QUEUE_DEPTH-1:0] cons_reg, cons_next;

    logic             sweep_busy_reg, sweep_busy_next;
    logic [TA_W-1:0]  sweep_reg, sweep_next;

    logic [SIG_W-1:0] q_mem [QUEUE_DEPTH];
    logic [SIG_W-1:0] q_rd_reg;
    logic [TW_W-1:0]  tbl_mem [TBL_DEPTH];
    logic [TW_W-1:0]  tbl_rd_reg;
    logic             ps_mem [NUM_STATES];
    logic             ps_rd_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [tdef_pkg::RK_W-1:0]      out_kind_reg, out_kind_next;
    logic                           out_err_reg, out_err_next;
    logic [SW-1:0]                  out_from_reg, out_from_next;
    logic [tdef_pkg::SIG_IN_W-1:0]  out_sig_reg, out_sig_next;
    logic [SW-1:0]                  out_to_reg, out_to_next;
    logic                           out_pse_reg, out_pse_next;
    logic [SW-1:0]                  out_cur_reg, out_cur_next;
    logic                           out_last_reg, out_last_next;

    logic             fire;
    logic             out_busy;
    logic             tbl_present;
    logic [SW-1:0]    tbl_tgt;
    logic [SIG_W-1:0] tbl_sig;
    logic             tgt_pseudo;
    logic [TA_W-1:0]  rd_addr;
    logic [TA_W-1:0]  wr_addr;
    logic             wr_ok;
    logic             st_ok;
    logic             push_ok;
    logic             exec;

    assign s_tready = (act == tdef_pkg::ACT_FETCH) && !sweep_busy_reg;
    assign fire     = s_tvalid && s_tready;
    assign out_busy = out_valid_reg && !m_tready;
    assign exec     = (act == tdef_pkg::ACT_EXEC);

    assign {tbl_present, tbl_tgt, tbl_sig} = tbl_rd_reg;
    assign tgt_pseudo = (int'(tbl_tgt) < NUM_STATES) && ps_rd_reg;

    assign rd_addr = TA_W'(int'(cur_reg) * ENTRIES_PER_STATE + int'(ei_reg));
    assign wr_addr = TA_W'(int'(st_reg) * ENTRIES_PER_STATE + int'(ein_reg));
    assign st_ok   = int'(st_reg) < NUM_STATES;
    assign wr_ok   = st_ok && (int'(ein_reg) < ENTRIES_PER_STATE);
    assign push_ok = int'(cnt_reg) < QUEUE_DEPTH;

    always_comb
    begin
        status.no_fire     = !fire;
        status.kind_run    = (kind_reg == tdef_pkg::KIND_RUN);
        status.qi_end      = (qi_reg >= cnt_reg);
        status.consumed    = cons_reg[qi_reg[QA_W-1:0]];
        status.ei_end      = (int'(ei_reg) >= ENTRIES_PER_STATE) ||
                             (int'(cur_reg) >= NUM_STATES);
        status.not_present = !tbl_present;
        status.match       = (tbl_sig == q_rd_reg);
        status.pseudo      = tgt_pseudo;
        status.out_busy    = out_busy;
    end

    // reset sweep clears the table and pseudo flags
    always_comb
    begin
        sweep_busy_next = sweep_busy_reg;
        sweep_next      = sweep_reg;
        if (sweep_busy_reg)
        begin
            sweep_next = sweep_reg + TA_W'(1);
            if (sweep_reg == TA_W'(TBL_DEPTH - 1))
            begin
                sweep_busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        cur_next  = cur_reg;
        cnt_next  = cnt_reg;
        qi_next   = qi_reg;
        ei_next   = ei_reg;
        err_next  = err_reg;
        cons_next = cons_reg;
        case (act)
            tdef_pkg::ACT_EXEC:
            begin
                err_next = 1'b0;
                case (kind_reg)
                    tdef_pkg::KIND_PUSH:
                    begin
                        if (push_ok)
                        begin
                            cons_next[cnt_reg[QA_W-1:0]] = 1'b0;
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        else
                        begin
                            err_next = 1'b1;
                        end
                    end
                    tdef_pkg::KIND_CLEAR: cnt_next = '0;
                    default: ;
                endcase
            end
            tdef_pkg::ACT_SCAN_START: qi_next = '0;
            tdef_pkg::ACT_EI_CLR:     ei_next = '0;
            tdef_pkg::ACT_EI_INC:     ei_next = ei_reg + EI_W'(1);
            tdef_pkg::ACT_HIT:        cons_next[qi_reg[QA_W-1:0]] = 1'b1;
            tdef_pkg::ACT_REPORT:
            begin
                if (!tgt_pseudo)
                begin
                    cur_next = tbl_tgt;
                end
            end
            tdef_pkg::ACT_QI_INC:     qi_next = qi_reg + CNT_W'(1);
            default: ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_err_next   = out_err_reg;
        out_from_next  = out_from_reg;
        out_sig_next   = out_sig_reg;
        out_to_next    = out_to_reg;
        out_pse_next   = out_pse_reg;
        out_cur_next   = out_cur_reg;
        out_last_next  = out_last_reg;
        case (act)
            tdef_pkg::ACT_ACK, tdef_pkg::ACT_DONE:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = (act == tdef_pkg::ACT_ACK) ? tdef_pkg::RK_ACK
                                                            : tdef_pkg::RK_DONE;
                out_err_next   = (act == tdef_pkg::ACT_ACK) && err_reg;
                out_from_next  = '0;
                out_sig_next   = '0;
                out_to_next    = '0;
                out_pse_next   = 1'b0;
                out_cur_next   = cur_reg;
                out_last_next  = 1'b1;
            end
            tdef_pkg::ACT_REPORT:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = tdef_pkg::RK_REPORT;
                out_err_next   = 1'b0;
                out_from_next  = cur_reg;
                out_sig_next   = tdef_pkg::SIG_IN_W'(q_rd_reg);
                out_to_next    = tbl_tgt;
                out_pse_next   = tgt_pseudo;
                out_cur_next   = tgt_pseudo ? cur_reg : tbl_tgt;
                out_last_next  = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            cnt_reg        <= '0;
            qi_reg         <= '0;
            ei_reg         <= '0;
            err_reg        <= 1'b0;
            cons_reg       <= '0;
            sweep_busy_reg <= 1'b1;
            sweep_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_reg        <= cur_next;
            cnt_reg        <= cnt_next;
            qi_reg         <= qi_next;
            ei_reg         <= ei_next;
            err_reg        <= err_next;
            cons_reg       <= cons_next;
            sweep_busy_reg <= sweep_busy_next;
            sweep_reg      <= sweep_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg  <= s_tuser;
            sig_reg   <= s_tdata[SIG_W-1:0];
            st_reg    <= s_tdata[12:8];
            ein_reg   <= s_tdata[15:13];
            tgt_reg   <= s_tdata[20:16];
            valid_reg <= s_tdata[21];
            pbit_reg  <= s_tdata[22];
        end
        out_kind_reg <= out_kind_next;
        out_err_reg  <= out_err_next;
        out_from_reg <= out_from_next;
        out_sig_reg  <= out_sig_next;
        out_to_reg   <= out_to_next;
        out_pse_reg  <= out_pse_next;
        out_cur_reg  <= out_cur_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (exec && (kind_reg == tdef_pkg::KIND_PUSH) && push_ok)
        begin
            q_mem[cnt_reg[QA_W-1:0]] <= sig_reg;
        end
        q_rd_reg <= q_mem[qi_reg[QA_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (sweep_busy_reg)
        begin
            tbl_mem[sweep_reg] <= '0;
        end
        else if (exec && (kind_reg == tdef_pkg::KIND_WR_ENTRY) && wr_ok)
        begin
            tbl_mem[wr_addr] <= {valid_reg, tgt_reg, sig_reg};
        end
        tbl_rd_reg <= tbl_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sweep_busy_reg)
        begin
            if (int'(sweep_reg) < NUM_STATES)
            begin
                ps_mem[PA_W'(sweep_reg)] <= 1'b0;
            end
        end
        else if (exec && (kind_reg == tdef_pkg::KIND_WR_PSEUDO) && st_ok)
        begin
            ps_mem[PA_W'(st_reg)] <= pbit_reg;
        end
        ps_rd_reg <= ps_mem[PA_W'(tbl_tgt)];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_cur_reg, out_pse_reg, out_to_reg, out_sig_reg,
                       out_from_reg, out_err_reg};

endmodule

// ===== hw/rtl/table_driven_event_fsm.sv =====
// Top level of the table-driven event state machine.
//
// One input stream (s_*) carries commands: push signal, run, clear queue,
// write transition entry, write pseudo flag; tuser holds the command kind.
// One output stream (m_*) carries results; tuser holds the result kind and
// tlast marks the final beat for a command.
// Push, clear, writes and unknown kinds end in a single ack beat.
// Run: a program of 16 microcode steps walks the queue and the entry list of
// the current state, and starts again from the oldest slot after each
// non-pseudo transition.
// After reset the transition table and pseudo flags are cleared, one word a
// cycle; s_tready stays low meanwhile.
// A stalled output holds its beat and the sequencer waits on the next result;
// a new command is taken while the last result of the previous one waits.
module table_driven_event_fsm #(
    parameter int NUM_STATES        = 32,
    parameter int ENTRIES_PER_STATE = 8,
    parameter int QUEUE_DEPTH       = 16,
    parameter int SIGNAL_BITS       = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // signal_value, state_index, entry_index, target_state, entry_valid, pseudo_bit
    input  logic [tdef_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind
    input  logic [tdef_pkg::KIND_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // error_flag, from_state, fired_signal, to_state, to_pseudo, current_state_out
    output logic [tdef_pkg::OUT_DATA_W-1:0] m_tdata,
    // result_kind
    output logic [tdef_pkg::RK_W-1:0]       m_tuser,
    output logic                            m_tlast
);

    tdef_pkg::act_t       act;
    tdef_pkg::dp_status_t status;

    tdef_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .act    (act)
    );

    tdef_dpath #(
        .NUM_STATES        (NUM_STATES),
        .ENTRIES_PER_STATE (ENTRIES_PER_STATE),
        .QUEUE_DEPTH       (QUEUE_DEPTH),
        .SIGNAL_BITS       (SIGNAL_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .act      (act),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/tdef_chk.sv =====
// Port-level checker for the table-driven event state machine, with its bind.
module tdef_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tdef_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [tdef_pkg::RK_W-1:0]       m_tuser,
    input logic                            m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                                  $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("command taken while a run is still reporting");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == tdef_pkg::RK_REPORT) == !m_tlast))
        else $error("tlast disagrees with result kind");

    a_pseudo_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == tdef_pkg::RK_REPORT) && m_tdata[19]
        |-> m_tdata[24:20] == m_tdata[5:1])
        else $error("pseudo transition changed the state");

endmodule

bind table_driven_event_fsm tdef_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
